@@ src/complex_integer_power_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the complex integer power block
// Shared clocking and reset handling for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_INTEGER_POWER_DEFINES_SVH
`define COMPLEX_INTEGER_POWER_DEFINES_SVH

// A property checked at every rising clock edge outside of reset.
`define CIP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define CIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/cip_pkg.sv @@
// ----------------------------------------------------------------------------
// cip_pkg
// Widths, sequencer states and the rounding unit's result type.
// ----------------------------------------------------------------------------
package cip_pkg;

	// Field and datapath widths.
	localparam int IN_W   = 16;
	localparam int EXP_W  = 4;
	localparam int DATA_W = 48;
	localparam int PROD_W = DATA_W + IN_W;
	// Sum of two products plus the rounding constant, with headroom.
	localparam int ACC_W  = PROD_W + 2;

	// Sequencer states: four products per complex multiplication.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_RA,
		ST_MUL_IB,
		ST_MUL_RB,
		ST_MUL_IA,
		ST_FIN,
		ST_DONE
	} cip_state_t;

	// Rounded and saturated part, with its saturation flag.
	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     sat;
	} cip_rs_t;

endpackage

@@ src/cip_round_sat.sv @@
// ----------------------------------------------------------------------------
// cip_round_sat
// Adds or subtracts a product to a biased accumulator, drops the fraction
// bits (round half up) and saturates to the 48-bit result range.
// ----------------------------------------------------------------------------
module cip_round_sat #(
	parameter int FRAC_BITS = 12
) (
	input  logic signed [cip_pkg::ACC_W-1:0]  acc,
	input  logic signed [cip_pkg::PROD_W-1:0] prod,
	input  logic                              add,
	output cip_pkg::cip_rs_t                  res
);
	import cip_pkg::*;

	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] sum;
	logic signed [ACC_W-1:0] shifted;
	logic                    fits;

	// The accumulator already holds the half LSB, so a floor shift rounds.
	assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	assign sum      = add ? (acc + prod_ext) : (acc - prod_ext);
	assign shifted  = sum >>> FRAC_BITS;

	// The value fits when every bit above the result's sign bit matches it.
	assign fits = (&shifted[ACC_W-1:DATA_W-1]) | ~(|shifted[ACC_W-1:DATA_W-1]);

	always_comb begin
		if (fits) begin
			res.val = shifted[DATA_W-1:0];
			res.sat = 1'b0;
		end else begin
			res.val = shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
			                           : {1'b0, {(DATA_W-1){1'b1}}};
			res.sat = 1'b1;
		end
	end

endmodule

@@ src/complex_integer_power.sv @@
// ----------------------------------------------------------------------------
// complex_integer_power
// Raises a Q3.12 complex number to a whole power by repeated multiplication.
// ----------------------------------------------------------------------------
// One transaction at a time: after an input is accepted, each power step
// runs through MUL_RA, MUL_IB, MUL_RB, MUL_IA and FIN on a single shared
// 48x16 signed multiplier (four partial products, then the final rounding
// of the imaginary part); the result follows n steps, with n clamped to
// MAX_EXPONENT (none for a zero exponent). A new input is accepted once the
// result has been taken. Each part is rounded half up to FRAC_BITS fraction
// bits and saturated after every step; overflow reports any saturation.
// ----------------------------------------------------------------------------
module complex_integer_power #(
	parameter int MAX_EXPONENT = 12,
	parameter int FRAC_BITS    = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [cip_pkg::IN_W-1:0]    real_in,
	input  logic signed [cip_pkg::IN_W-1:0]    imag_in,
	input  logic        [cip_pkg::EXP_W-1:0]   exponent,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [cip_pkg::DATA_W-1:0]  real_out,
	output logic signed [cip_pkg::DATA_W-1:0]  imag_out,
	output logic                               overflow
);
	import cip_pkg::*;

	localparam logic [EXP_W-1:0] MAX_EXP = EXP_W'(MAX_EXPONENT);
	localparam logic [DATA_W-1:0] ONE    = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [ACC_W-1:0]  HALF   = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	cip_state_t state_q, state_d;
	logic [EXP_W-1:0] cnt_q;
	logic [EXP_W-1:0] n_clamp;
	logic             in_acc;

	logic signed [IN_W-1:0]   a_q, b_q;
	logic signed [DATA_W-1:0] re_q, im_q, nr_q;
	logic                     ovf_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [DATA_W-1:0] mul_x;
	logic signed [IN_W-1:0]   mul_y;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ACC_W-1:0]  prod_biased;
	cip_rs_t                  rs;

	assign in_acc  = in_valid && in_ready;
	assign n_clamp = (exponent > MAX_EXP) ? MAX_EXP : exponent;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (n_clamp == '0) ? ST_DONE : ST_MUL_RA;
				end
			end
			ST_MUL_RA: state_d = ST_MUL_IB;
			ST_MUL_IB: state_d = ST_MUL_RB;
			ST_MUL_RB: state_d = ST_MUL_IA;
			ST_MUL_IA: state_d = ST_FIN;
			ST_FIN: begin
				state_d = (cnt_q == EXP_W'(1)) ? ST_DONE : ST_MUL_RA;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Remaining power steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			cnt_q <= n_clamp;
		end else if (state_q == ST_FIN) begin
			cnt_q <= cnt_q - EXP_W'(1);
		end
	end

	// Shared multiplier operand selection: re*a, im*b, re*b, im*a.
	always_comb begin
		case (state_q)
			ST_MUL_IB, ST_MUL_IA: mul_x = im_q;
			default:              mul_x = re_q;
		endcase
		case (state_q)
			ST_MUL_IB, ST_MUL_RB: mul_y = b_q;
			default:              mul_y = a_q;
		endcase
	end

	assign mul_p       = PROD_W'(mul_x) * PROD_W'(mul_y);
	assign prod_biased = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} + $signed(HALF);

	// Real part subtracts im*b; imaginary part adds im*a.
	cip_round_sat #(
		.FRAC_BITS(FRAC_BITS)
	) u_round_sat (
		.acc (acc_q),
		.prod(prod_q),
		.add (state_q == ST_FIN),
		.res (rs)
	);

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					a_q   <= real_in;
					b_q   <= imag_in;
					re_q  <= $signed(ONE);
					im_q  <= '0;
					ovf_q <= 1'b0;
				end
			end
			ST_MUL_IB, ST_MUL_IA: acc_q <= prod_biased;
			ST_MUL_RB: begin
				nr_q  <= rs.val;
				ovf_q <= ovf_q | rs.sat;
			end
			ST_FIN: begin
				re_q  <= nr_q;
				im_q  <= rs.val;
				ovf_q <= ovf_q | rs.sat;
			end
			default: begin
			end
		endcase
	end

	assign real_out = re_q;
	assign imag_out = im_q;
	assign overflow = ovf_q;

endmodule

@@ src/cip_checker.sv @@
// ----------------------------------------------------------------------------
// cip_checker
// Port-level checks of the complex integer power block, bound to the top.
// ----------------------------------------------------------------------------
`include "complex_integer_power_defines.svh"

module cip_checker #(
	parameter int FRAC_BITS = 12
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic        [cip_pkg::EXP_W-1:0]   exponent,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [cip_pkg::DATA_W-1:0]  real_out,
	input logic signed [cip_pkg::DATA_W-1:0]  imag_out,
	input logic                               overflow
);
	import cip_pkg::*;

	localparam logic [DATA_W-1:0] ONE = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

	// The block works on one transaction at a time.
	`CIP_ASSERT(a_one_at_a_time, !(in_ready && out_valid), "ready while a result waits")

	// An accepted input makes the block busy.
	`CIP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

	// A zero power gives exactly one with no overflow on the next cycle.
	`CIP_ASSERT_NEXT(a_zero_power, in_valid && in_ready && exponent == '0,
		out_valid && real_out == $signed(ONE) && imag_out == '0 && !overflow,
		"zero power result wrong")

	// A result held under back-pressure does not change.
	`CIP_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
		out_valid && $stable(real_out) && $stable(imag_out) && $stable(overflow),
		"result changed while stalled")

	// Delivering a result returns the block to accepting input.
	`CIP_ASSERT_NEXT(a_ready_after_result, out_valid && out_ready, in_ready,
		"not ready after result")

endmodule

bind complex_integer_power cip_checker #(.FRAC_BITS(FRAC_BITS)) u_cip_checker (.*);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for complex_integer_power
// Sends complex Q3.12 operands with exponents 0 to 15 through the valid/ready
// input channel, predicts each power with a bit-exact fixed-point model, and
// compares every result transaction in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import cip_pkg::*;

	localparam int MAX_EXP   = 12;
	localparam int FRAC      = 12;
	localparam int WIDE_W    = 80;
	localparam int N_RANDOM  = 1530;
	localparam int MAX_SHOWN = 10;

	localparam logic signed [WIDE_W-1:0] ROUND_HALF = 80'sd1 <<< (FRAC - 1);
	localparam logic signed [WIDE_W-1:0] PART_MAX   = (80'sd1 <<< (DATA_W - 1)) - 80'sd1;
	localparam logic signed [WIDE_W-1:0] PART_MIN   = -(80'sd1 <<< (DATA_W - 1));

	// One operand transaction waiting to be sent.
	typedef struct {
		logic signed [IN_W-1:0] re_part;
		logic signed [IN_W-1:0] im_part;
		logic [EXP_W-1:0]       power;
		bit                     drain;
	} power_req_t;

	// One predicted power.
	typedef struct {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic                     ovf;
	} power_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [IN_W-1:0]   real_in = '0;
	logic signed [IN_W-1:0]   imag_in = '0;
	logic [EXP_W-1:0]         exponent = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] real_out;
	logic signed [DATA_W-1:0] imag_out;
	logic                     overflow;

	power_req_t operand_q[$];
	power_t     power_q[$];
	int         sent_count = 0;
	int         rcv_count = 0;
	int         fail_count = 0;
	int         send_gap = 0;
	int         take_stall = 0;
	bit         send_burst = 1'b0;
	bit         take_burst = 1'b0;

	complex_integer_power #(
		.MAX_EXPONENT(MAX_EXP),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.real_in(real_in),
		.imag_in(imag_in),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.real_out(real_out),
		.imag_out(imag_out),
		.overflow(overflow)
	);

	// Clock and a single reset pulse at the start.
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Rounds an exact sum of products half up and clamps it to 48 bits.
	function automatic cip_rs_t round_part(input logic signed [WIDE_W-1:0] sum);
		cip_rs_t r;
		logic signed [WIDE_W-1:0] q;
		q = (sum + ROUND_HALF) >>> FRAC;
		r.sat = 1'b0;
		if (q > PART_MAX) begin
			r.val = PART_MAX[DATA_W-1:0];
			r.sat = 1'b1;
		end else if (q < PART_MIN) begin
			r.val = PART_MIN[DATA_W-1:0];
			r.sat = 1'b1;
		end else begin
			r.val = q[DATA_W-1:0];
		end
		return r;
	endfunction

	// Repeated complex multiplication from 1+0i, rounding after every step.
	// The sums are exact in 80 bits, so any sum beyond 64 bits lands past the
	// 48-bit limits with the same sign and saturates the same way.
	function automatic power_t raise_power(input logic signed [IN_W-1:0] a,
			input logic signed [IN_W-1:0] b, input logic [EXP_W-1:0] n);
		power_t p;
		cip_rs_t nr;
		cip_rs_t ni;
		logic signed [WIDE_W-1:0] wa;
		logic signed [WIDE_W-1:0] wb;
		logic signed [WIDE_W-1:0] wr;
		logic signed [WIDE_W-1:0] wi;
		int steps;
		wa = WIDE_W'(a);
		wb = WIDE_W'(b);
		p.re = 48'sd1 <<< FRAC;
		p.im = '0;
		p.ovf = 1'b0;
		steps = (n > MAX_EXP) ? MAX_EXP : n;
		for (int i = 0; i < steps; i++) begin
			wr = WIDE_W'(p.re);
			wi = WIDE_W'(p.im);
			nr = round_part(wr * wa - wi * wb);
			ni = round_part(wr * wb + wi * wa);
			p.re = nr.val;
			p.im = ni.val;
			p.ovf = p.ovf | nr.sat | ni.sat;
		end
		return p;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_SHOWN)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic add_operand(input int a, input int b, input int n, input bit drain);
		power_req_t r;
		r.re_part = a[IN_W-1:0];
		r.im_part = b[IN_W-1:0];
		r.power = n[EXP_W-1:0];
		r.drain = drain;
		operand_q.push_back(r);
	endtask

	// Random component with a magnitude class chosen by the caller.
	function automatic int pick_part(input int mag);
		case (mag)
			0: return $urandom_range(0, 12000) - 6000;
			1: return $urandom_range(0, 128) - 64;
			2: return $urandom_range(0, 65535) - 32768;
			default: begin
				case ($urandom_range(0, 5))
					0: return 0;
					1: return 4096;
					2: return -4096;
					3: return 32767;
					4: return -32768;
					default: return 2048;
				endcase
			end
		endcase
	endfunction

	// Operand driver: sends queued transactions with random gaps between them.
	// A drain-marked operand waits until every earlier result has come back.
	always @(posedge clk or negedge arst_n) begin
		power_req_t next_op;
		bit fire;
		if (!arst_n) begin
			in_valid <= 1'b0;
			real_in <= '0;
			imag_in <= '0;
			exponent <= '0;
			send_gap = 0;
		end else begin
			fire = in_valid && in_ready;
			if (fire) begin
				power_q.push_back(raise_power(real_in, imag_in, exponent));
				sent_count <= sent_count + 1;
				if ($urandom_range(0, 49) == 0)
					send_burst = !send_burst;
				send_gap = send_burst ? 0 : $urandom_range(0, 19);
			end
			if (in_valid && !fire) begin
				// Hold the transaction until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (operand_q.size() > 0 &&
					(!operand_q[0].drain || (!fire && sent_count == rcv_count))) begin
				next_op = operand_q.pop_front();
				real_in <= next_op.re_part;
				imag_in <= next_op.im_part;
				exponent <= next_op.power;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: checks each result in order and stalls ready at random
	// while a result is on offer.
	always @(posedge clk or negedge arst_n) begin
		power_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_stall = $urandom_range(0, 19);
		end else begin
			if (out_valid && out_ready) begin
				rcv_count <= rcv_count + 1;
				if (power_q.size() == 0) begin
					note_failure($sformatf("result with nothing expected: re=%0d im=%0d ovf=%0b",
						real_out, imag_out, overflow));
				end else begin
					want = power_q.pop_front();
					if (real_out !== want.re || imag_out !== want.im || overflow !== want.ovf)
						note_failure($sformatf(
							"expected re=%0d im=%0d ovf=%0b, got re=%0d im=%0d ovf=%0b",
							want.re, want.im, want.ovf, real_out, imag_out, overflow));
				end
				if ($urandom_range(0, 49) == 0)
					take_burst = !take_burst;
				take_stall = take_burst ? 0 : $urandom_range(0, 19);
			end else if (out_valid && take_stall > 0) begin
				take_stall--;
			end
			out_ready <= (take_stall == 0);
		end
	end

	// Stimulus and end of run.
	initial begin
		int cls;
		int a;
		int b;
		int n;
		int n_items;
		// Zero exponent gives one, whatever the operand; one to the first power stays one.
		add_operand(0, 0, 0, 1'b0);
		add_operand(32767, -32768, 0, 1'b0);
		add_operand(4096, 0, 1, 1'b0);
		// Powers of i walk around the unit circle.
		add_operand(0, 4096, 1, 1'b0);
		add_operand(0, 4096, 2, 1'b0);
		add_operand(0, 4096, 3, 1'b0);
		add_operand(0, 4096, 4, 1'b0);
		// Field extremes, saturating both parts and feeding the clamped values on.
		add_operand(-32768, -32768, 12, 1'b0);
		add_operand(32767, 32767, 12, 1'b0);
		add_operand(-32768, 0, 1, 1'b0);
		add_operand(0, -32768, 2, 1'b0);
		add_operand(32767, 0, 12, 1'b0);
		add_operand(-32768, 32767, 7, 1'b0);
		// Exponents above the maximum are clamped.
		add_operand(32767, 32767, 15, 1'b0);
		add_operand(4096, 4096, 13, 1'b0);
		add_operand(-4096, 2896, 14, 1'b0);
		// Rounding ties go toward plus infinity, for both signs.
		add_operand(48, 16, 2, 1'b0);
		add_operand(16, 48, 2, 1'b0);
		add_operand(1, 1, 2, 1'b0);
		add_operand(-1, -1, 3, 1'b0);
		// Near the unit circle, no saturation.
		add_operand(4095, -4096, 12, 1'b0);
		add_operand(2896, 2896, 8, 1'b0);

		for (int i = 0; i < N_RANDOM; i++) begin
			cls = $urandom_range(0, 99);
			n = $urandom_range(0, MAX_EXP);
			if (cls < 40) begin
				a = pick_part(0);
				b = pick_part(0);
			end else if (cls < 65) begin
				a = pick_part(2);
				b = pick_part(2);
				n = $urandom_range(0, 15);
			end else if (cls < 80) begin
				a = pick_part(1);
				b = pick_part(1);
			end else if (cls < 90) begin
				a = pick_part(3);
				b = pick_part($urandom_range(0, 3));
			end else begin
				a = pick_part($urandom_range(0, 3));
				b = pick_part($urandom_range(0, 3));
				n = $urandom_range(MAX_EXP + 1, 15);
			end
			add_operand(a, b, n, (i == 0) || (i == N_RANDOM / 2));
		end
		n_items = operand_q.size();

		// Every queued transaction must come back before the run can pass.
		@(posedge arst_n);
		while (rcv_count != n_items)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (power_q.size() != 0)
			note_failure($sformatf("%0d expected results never arrived", power_q.size()));
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
